// ===== src/olm_pkg.sv =====
// olm_pkg: types, codes and widths shared by the ordered list manager
// no dependencies
`timescale 1ns / 1ps

package olm_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int CMD_W        = 3;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 16;
  localparam int ST_W         = 3;
  localparam int FPOS_W       = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_LIST     = 3'd0,
    CMD_INS_HEAD = 3'd1,
    CMD_INS_TAIL = 3'd2,
    CMD_INS_POS  = 3'd3,
    CMD_DEL_HEAD = 3'd4,
    CMD_DEL_TAIL = 3'd5,
    CMD_DEL_VAL  = 3'd6,
    CMD_SEARCH   = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    DP_IDLE       = 5'd0,
    DP_LOAD       = 5'd1,
    DP_START_WALK = 5'd2,
    DP_WALK_RD    = 5'd3,
    DP_WALK_ADV   = 5'd4,
    DP_WALK_END   = 5'd5,
    DP_RD_FREE    = 5'd6,
    DP_INS_TAKE   = 5'd7,
    DP_RD_PREV    = 5'd8,
    DP_INS_LINK   = 5'd9,
    DP_INS_PREV   = 5'd10,
    DP_DEL_NODE   = 5'd11,
    DP_RD_NODE    = 5'd12,
    DP_DEL_UNLINK = 5'd13,
    DP_DEL_FREE   = 5'd14,
    DP_FIND_START = 5'd15,
    DP_RD_CUR     = 5'd16,
    DP_FIND_ADV   = 5'd17,
    DP_FIND_HIT   = 5'd18,
    DP_LIST_OUT   = 5'd19,
    DP_RESULT     = 5'd20
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t status;
    logic    use_pos;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic full;
    logic pos_bad;
    logic at_head;
    logic rem_zero;
    logic match;
    logic at_end;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== src/olm_in_if.sv =====
// olm_in_if: command channel, valid/ready with command payload
// depends on olm_pkg
`timescale 1ns / 1ps

interface olm_in_if;
  logic                                valid;
  logic                                ready;
  logic [olm_pkg::CMD_W-1:0]           command;
  logic signed [olm_pkg::VAL_W-1:0]    value;
  logic [olm_pkg::POS_W-1:0]           position;

  modport source (output valid, command, value, position, input ready);
  modport sink (input valid, command, value, position, output ready);
endinterface

// ===== src/olm_out_if.sv =====
// olm_out_if: result channel, valid/ready with result payload
// depends on olm_pkg
`timescale 1ns / 1ps

interface olm_out_if;
  logic                                valid;
  logic                                ready;
  logic [olm_pkg::ST_W-1:0]            status;
  logic signed [olm_pkg::VAL_W-1:0]    data;
  logic [olm_pkg::FPOS_W-1:0]          found_position;
  logic                                last;

  modport source (output valid, status, data, found_position, last, input ready);
  modport sink (input valid, status, data, found_position, last, output ready);
endinterface

// ===== src/olm_datapath.sv =====
// olm_datapath: node stores, list pointers, walk registers and result register
// depends on olm_pkg and olm_out_if
`timescale 1ns / 1ps

module olm_datapath #(
  parameter int CAPACITY = olm_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  olm_pkg::ctrl_cmd_t               ctrl,
  output olm_pkg::dp_stat_t                stat,
  input  logic [olm_pkg::CMD_W-1:0]        command,
  input  logic signed [olm_pkg::VAL_W-1:0] value,
  input  logic [olm_pkg::POS_W-1:0]        position,
  olm_out_if.source                        out_ch
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = $clog2(CAPACITY + 1);
  localparam logic [PW-1:0] NULL_IDX = PW'(CAPACITY);

  logic [PW-1:0]                  link_mem [CAPACITY];
  logic [CAPACITY-1:0]            link_vld;
  logic [olm_pkg::VAL_W-1:0]      value_mem [CAPACITY];

  olm_pkg::cmd_t                  cmd_r;
  logic [olm_pkg::VAL_W-1:0]      val_r;
  logic [olm_pkg::POS_W-1:0]      pos_r;
  logic [PW-1:0]                  head;
  logic [PW-1:0]                  free_h;
  logic [PW-1:0]                  count;
  logic [PW-1:0]                  cur;
  logic [PW-1:0]                  prev;
  logic [PW-1:0]                  node;
  logic [PW-1:0]                  rem;
  logic [PW-1:0]                  k;
  logic [PW-1:0]                  lnk_q;
  logic [olm_pkg::VAL_W-1:0]      val_q;

  logic                           out_valid;
  olm_pkg::status_t               out_status;
  logic [olm_pkg::VAL_W-1:0]      out_data;
  logic [olm_pkg::FPOS_W-1:0]     out_fpos;
  logic                           out_last;

  logic                           rd_en;
  logic [PW-1:0]                  rd_addr;
  logic                           lk_we;
  logic [PW-1:0]                  lk_wa;
  logic [PW-1:0]                  lk_wd;
  logic [PW-1:0]                  p_eff;
  logic [IW-1:0]                  ra;
  logic [IW-1:0]                  wa;

  // effective position for positional work
  always_comb begin
    unique case (cmd_r)
      olm_pkg::CMD_INS_TAIL: p_eff = count + PW'(1);
      olm_pkg::CMD_INS_POS:  p_eff = pos_r[PW-1:0];
      olm_pkg::CMD_DEL_TAIL: p_eff = count;
      default:               p_eff = PW'(1);
    endcase
  end

  always_comb begin
    stat.cmd      = cmd_r;
    stat.empty    = (count == '0);
    stat.full     = (count == NULL_IDX);
    stat.pos_bad  = (pos_r == '0) ||
                    ({1'b0, pos_r} > ((olm_pkg::POS_W+1)'(count) + 17'd1));
    stat.at_head  = (p_eff == PW'(1));
    stat.rem_zero = (rem == '0);
    stat.match    = (val_q == val_r);
    stat.at_end   = (k == count);
    stat.out_busy = out_valid;
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = cur;
    lk_we   = 1'b0;
    lk_wa   = node;
    lk_wd   = free_h;
    unique case (ctrl.op)
      olm_pkg::DP_WALK_RD, olm_pkg::DP_RD_CUR: rd_addr = cur;
      olm_pkg::DP_RD_FREE: rd_addr = free_h;
      olm_pkg::DP_RD_PREV: rd_addr = prev;
      olm_pkg::DP_RD_NODE: rd_addr = node;
      default:             rd_en   = 1'b0;
    endcase
    unique case (ctrl.op)
      olm_pkg::DP_INS_TAKE: begin
        lk_we = (prev == NULL_IDX);
        lk_wa = free_h;
        lk_wd = head;
      end
      olm_pkg::DP_INS_LINK: begin
        lk_we = 1'b1;
        lk_wa = node;
        lk_wd = lnk_q;
      end
      olm_pkg::DP_INS_PREV: begin
        lk_we = 1'b1;
        lk_wa = prev;
        lk_wd = node;
      end
      olm_pkg::DP_DEL_UNLINK: begin
        lk_we = (prev != NULL_IDX);
        lk_wa = prev;
        lk_wd = lnk_q;
      end
      olm_pkg::DP_DEL_FREE: begin
        lk_we = 1'b1;
        lk_wa = node;
        lk_wd = free_h;
      end
      default: lk_we = 1'b0;
    endcase
  end

  assign ra = rd_addr[IW-1:0];
  assign wa = lk_wa[IW-1:0];

  // node stores, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      lnk_q <= link_vld[ra] ? link_mem[ra] : (PW'(ra) + PW'(1));
      val_q <= value_mem[ra];
    end
    if (lk_we) begin
      link_mem[wa] <= lk_wd;
    end
    if (ctrl.op == olm_pkg::DP_INS_TAKE) begin
      value_mem[free_h[IW-1:0]] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (lk_we) begin
      link_vld[wa] <= 1'b1;
    end
  end

  // list pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= NULL_IDX;
      free_h <= '0;
      count  <= '0;
    end else begin
      unique case (ctrl.op)
        olm_pkg::DP_INS_TAKE: begin
          free_h <= lnk_q;
          if (prev == NULL_IDX) begin
            head  <= free_h;
            count <= count + PW'(1);
          end
        end
        olm_pkg::DP_INS_PREV: count <= count + PW'(1);
        olm_pkg::DP_DEL_UNLINK: begin
          if (prev == NULL_IDX) begin
            head <= lnk_q;
          end
        end
        olm_pkg::DP_DEL_FREE: begin
          free_h <= node;
          count  <= count - PW'(1);
        end
        default: ;
      endcase
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      olm_pkg::DP_LOAD: begin
        cmd_r <= olm_pkg::cmd_t'(command);
        val_r <= value;
        pos_r <= position;
      end
      olm_pkg::DP_START_WALK: begin
        cur  <= head;
        node <= head;
        prev <= NULL_IDX;
        rem  <= p_eff - PW'(2);
      end
      olm_pkg::DP_WALK_ADV: begin
        cur <= lnk_q;
        rem <= rem - PW'(1);
      end
      olm_pkg::DP_WALK_END: prev <= cur;
      olm_pkg::DP_INS_TAKE: node <= free_h;
      olm_pkg::DP_DEL_NODE: node <= lnk_q;
      olm_pkg::DP_FIND_START: begin
        cur  <= head;
        prev <= NULL_IDX;
        k    <= PW'(1);
      end
      olm_pkg::DP_FIND_ADV: begin
        prev <= cur;
        cur  <= lnk_q;
        k    <= k + PW'(1);
      end
      olm_pkg::DP_FIND_HIT: node <= cur;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == olm_pkg::DP_LIST_OUT || ctrl.op == olm_pkg::DP_RESULT) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == olm_pkg::DP_LIST_OUT) begin
      out_status <= olm_pkg::ST_OK;
      out_data   <= val_q;
      out_fpos   <= '0;
      out_last   <= (k == count);
    end else if (ctrl.op == olm_pkg::DP_RESULT) begin
      out_status <= ctrl.status;
      out_data   <= '0;
      out_fpos   <= ctrl.use_pos ? olm_pkg::FPOS_W'(k) : '0;
      out_last   <= 1'b1;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.data           = out_data;
  assign out_ch.found_position = out_fpos;
  assign out_ch.last           = out_last;

endmodule

// ===== src/olm_ctrl.sv =====
// olm_ctrl: command sequencer for the ordered list manager
// depends on olm_pkg
`timescale 1ns / 1ps

module olm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  olm_pkg::dp_stat_t   stat,
  output olm_pkg::ctrl_cmd_t  ctrl
);

  typedef enum logic [19:0] {
    S_IDLE       = 20'h00001,
    S_DECODE     = 20'h00002,
    S_WALK       = 20'h00004,
    S_WALK_WAIT  = 20'h00008,
    S_INS_RD     = 20'h00010,
    S_INS_TAKE   = 20'h00020,
    S_INS_RDP    = 20'h00040,
    S_INS_LINK   = 20'h00080,
    S_INS_PREV   = 20'h00100,
    S_DEL_RDP    = 20'h00200,
    S_DEL_NODE   = 20'h00400,
    S_DEL_RDN    = 20'h00800,
    S_DEL_UNLINK = 20'h01000,
    S_DEL_FREE   = 20'h02000,
    S_FIND_RD    = 20'h04000,
    S_FIND_CMP   = 20'h08000,
    S_LIST_RD    = 20'h10000,
    S_LIST_OUT   = 20'h20000,
    S_LIST_WAIT  = 20'h40000,
    S_RESP       = 20'h80000
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_ins;
  logic   s_ok_pending;
  logic   s_ok_pending_next;

  assign is_ins = (stat.cmd == olm_pkg::CMD_INS_HEAD) ||
                  (stat.cmd == olm_pkg::CMD_INS_TAIL) ||
                  (stat.cmd == olm_pkg::CMD_INS_POS);

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      s_ok_pending <= 1'b0;
    end else begin
      state        <= state_next;
      s_ok_pending <= s_ok_pending_next;
    end
  end

  // ok result after a completed change goes out from the response state
  always_comb begin
    state_next        = state;
    s_ok_pending_next = 1'b0;
    ctrl.op           = olm_pkg::DP_IDLE;
    ctrl.status       = olm_pkg::ST_OK;
    ctrl.use_pos      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.op    = olm_pkg::DP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.cmd)
          olm_pkg::CMD_LIST: begin
            if (stat.empty) begin
              ctrl.op     = olm_pkg::DP_RESULT;
              ctrl.status = olm_pkg::ST_EMPTY;
              state_next  = S_RESP;
            end else begin
              ctrl.op    = olm_pkg::DP_FIND_START;
              state_next = S_LIST_RD;
            end
          end
          olm_pkg::CMD_INS_HEAD, olm_pkg::CMD_INS_TAIL, olm_pkg::CMD_INS_POS: begin
            if (stat.full) begin
              ctrl.op     = olm_pkg::DP_RESULT;
              ctrl.status = olm_pkg::ST_FULL;
              state_next  = S_RESP;
            end else if (stat.cmd == olm_pkg::CMD_INS_POS && stat.pos_bad) begin
              ctrl.op     = olm_pkg::DP_RESULT;
              ctrl.status = olm_pkg::ST_BADPOS;
              state_next  = S_RESP;
            end else begin
              ctrl.op    = olm_pkg::DP_START_WALK;
              state_next = stat.at_head ? S_INS_RD : S_WALK;
            end
          end
          olm_pkg::CMD_DEL_HEAD, olm_pkg::CMD_DEL_TAIL: begin
            if (stat.empty) begin
              ctrl.op     = olm_pkg::DP_RESULT;
              ctrl.status = olm_pkg::ST_EMPTY;
              state_next  = S_RESP;
            end else begin
              ctrl.op    = olm_pkg::DP_START_WALK;
              state_next = stat.at_head ? S_DEL_RDN : S_WALK;
            end
          end
          default: begin
            if (stat.empty) begin
              ctrl.op     = olm_pkg::DP_RESULT;
              ctrl.status = olm_pkg::ST_EMPTY;
              state_next  = S_RESP;
            end else begin
              ctrl.op    = olm_pkg::DP_FIND_START;
              state_next = S_FIND_RD;
            end
          end
        endcase
      end
      S_WALK: begin
        if (stat.rem_zero) begin
          ctrl.op    = olm_pkg::DP_WALK_END;
          state_next = is_ins ? S_INS_RD : S_DEL_RDP;
        end else begin
          ctrl.op    = olm_pkg::DP_WALK_RD;
          state_next = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        ctrl.op    = olm_pkg::DP_WALK_ADV;
        state_next = S_WALK;
      end
      S_INS_RD: begin
        ctrl.op    = olm_pkg::DP_RD_FREE;
        state_next = S_INS_TAKE;
      end
      S_INS_TAKE: begin
        ctrl.op = olm_pkg::DP_INS_TAKE;
        if (stat.at_head) begin
          s_ok_pending_next = 1'b1;
          state_next        = S_RESP;
        end else begin
          state_next = S_INS_RDP;
        end
      end
      S_INS_RDP: begin
        ctrl.op    = olm_pkg::DP_RD_PREV;
        state_next = S_INS_LINK;
      end
      S_INS_LINK: begin
        ctrl.op    = olm_pkg::DP_INS_LINK;
        state_next = S_INS_PREV;
      end
      S_INS_PREV: begin
        ctrl.op           = olm_pkg::DP_INS_PREV;
        s_ok_pending_next = 1'b1;
        state_next        = S_RESP;
      end
      S_DEL_RDP: begin
        ctrl.op    = olm_pkg::DP_RD_PREV;
        state_next = S_DEL_NODE;
      end
      S_DEL_NODE: begin
        ctrl.op    = olm_pkg::DP_DEL_NODE;
        state_next = S_DEL_RDN;
      end
      S_DEL_RDN: begin
        ctrl.op    = olm_pkg::DP_RD_NODE;
        state_next = S_DEL_UNLINK;
      end
      S_DEL_UNLINK: begin
        ctrl.op    = olm_pkg::DP_DEL_UNLINK;
        state_next = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        ctrl.op           = olm_pkg::DP_DEL_FREE;
        s_ok_pending_next = 1'b1;
        state_next        = S_RESP;
      end
      S_FIND_RD: begin
        ctrl.op    = olm_pkg::DP_RD_CUR;
        state_next = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (stat.match) begin
          if (stat.cmd == olm_pkg::CMD_SEARCH) begin
            ctrl.op      = olm_pkg::DP_RESULT;
            ctrl.use_pos = 1'b1;
            state_next   = S_RESP;
          end else begin
            ctrl.op    = olm_pkg::DP_FIND_HIT;
            state_next = S_DEL_RDN;
          end
        end else if (stat.at_end) begin
          ctrl.op     = olm_pkg::DP_RESULT;
          ctrl.status = olm_pkg::ST_NOTFOUND;
          state_next  = S_RESP;
        end else begin
          ctrl.op    = olm_pkg::DP_FIND_ADV;
          state_next = S_FIND_RD;
        end
      end
      S_LIST_RD: begin
        ctrl.op    = olm_pkg::DP_RD_CUR;
        state_next = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        ctrl.op    = olm_pkg::DP_LIST_OUT;
        state_next = S_LIST_WAIT;
      end
      S_LIST_WAIT: begin
        if (!stat.out_busy) begin
          if (stat.at_end) begin
            state_next = S_IDLE;
          end else begin
            ctrl.op    = olm_pkg::DP_FIND_ADV;
            state_next = S_LIST_RD;
          end
        end
      end
      S_RESP: begin
        if (s_ok_pending) begin
          ctrl.op = olm_pkg::DP_RESULT;
        end else if (!stat.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/ordered_list_manager_core.sv =====
// ordered_list_manager_core: linked list of signed values over a node store
// a rejected command gets its result straight from the decode state, with no walk
// one command at a time: a new command is taken only in idle, after its last result is accepted
// a list command gives one result transfer per entry
// synchronous reset empties the list and rebuilds the free chain at once
// depends on olm_pkg, olm_in_if, olm_out_if, olm_ctrl, olm_datapath
`timescale 1ns / 1ps

module ordered_list_manager_core #(
  parameter int CAPACITY = olm_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  olm_in_if.sink    in_ch,
  olm_out_if.source out_ch
);

  olm_pkg::ctrl_cmd_t ctrl;
  olm_pkg::dp_stat_t  stat;
  logic               in_ready;

  assign in_ch.ready = in_ready;

  olm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  olm_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .stat     (stat),
    .command  (in_ch.command),
    .value    (in_ch.value),
    .position (in_ch.position),
    .out_ch   (out_ch)
  );

endmodule

// ===== verif/tb.sv =====
// tb: self-checking bench for ordered_list_manager_core, a bounded linked list
// random and directed commands are checked against a behavioral list kept here
// depends on olm_pkg, olm_in_if, olm_out_if and the core
`timescale 1ns / 1ps

module tb;

  localparam int CAP = olm_pkg::CAPACITY_DEF;

  typedef struct packed {
    olm_pkg::cmd_t      cmd;
    logic signed [31:0] value;
    logic [15:0]        position;
  } cmd_item_t;

  typedef struct packed {
    olm_pkg::status_t   status;
    logic signed [31:0] data;
    logic [6:0]         fpos;
    logic               last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  olm_in_if  in_ch ();
  olm_out_if out_ch ();

  ordered_list_manager_core #(.CAPACITY(CAP)) uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  cmd_item_t pending_cmds[$];
  result_t   expected_results[$];
  logic signed [31:0] list_vals[$];
  int errors = 0;
  int checked = 0;
  int accepted = 0;
  int sent_gap = 0;
  int recv_gap = 0;
  int hist[8];
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;

  // predicted behavior of one command on the mirrored list
  function automatic void apply_cmd(cmd_item_t c);
    result_t r;
    int n, p;
    n = list_vals.size();
    r = '{status: olm_pkg::ST_OK, data: 32'sd0, fpos: 7'd0, last: 1'b1};
    p = 0;
    case (c.cmd)
      olm_pkg::CMD_LIST: begin
        if (n == 0) r.status = olm_pkg::ST_EMPTY;
        else begin
          for (int i = 0; i < n; i++) begin
            expected_results.push_back('{status: olm_pkg::ST_OK, data: list_vals[i],
                                         fpos: 7'd0, last: (i == n - 1)});
          end
          return;
        end
      end
      olm_pkg::CMD_INS_HEAD, olm_pkg::CMD_INS_TAIL, olm_pkg::CMD_INS_POS: begin
        if (n >= CAP) r.status = olm_pkg::ST_FULL;
        else begin
          p = (c.cmd == olm_pkg::CMD_INS_HEAD) ? 1 :
              (c.cmd == olm_pkg::CMD_INS_TAIL) ? n + 1 : int'(c.position);
          if (p == 0 || p > n + 1) r.status = olm_pkg::ST_BADPOS;
          else list_vals.insert(p - 1, c.value);
        end
      end
      olm_pkg::CMD_DEL_HEAD, olm_pkg::CMD_DEL_TAIL: begin
        if (n == 0) r.status = olm_pkg::ST_EMPTY;
        else if (c.cmd == olm_pkg::CMD_DEL_HEAD) void'(list_vals.pop_front());
        else void'(list_vals.pop_back());
      end
      default: begin
        if (n == 0) r.status = olm_pkg::ST_EMPTY;
        else begin
          for (int i = 0; i < n; i++) begin
            if (list_vals[i] == c.value) begin
              p = i + 1;
              break;
            end
          end
          if (p == 0) r.status = olm_pkg::ST_NOTFOUND;
          else if (c.cmd == olm_pkg::CMD_DEL_VAL) list_vals.delete(p - 1);
          else r.fpos = 7'(p);
        end
      end
    endcase
    expected_results.push_back(r);
  endfunction

  // transfers seen at the last rising edge
  always @(posedge clk) begin
    in_fire  <= !rst && in_ch.valid && in_ch.ready;
    out_fire <= !rst && out_ch.valid && out_ch.ready;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
    end else if (sent_gap > 0) begin
      in_ch.valid <= 1'b0;
      sent_gap <= sent_gap - 1;
    end else if (pending_cmds.size() > 0) begin
      in_ch.valid <= 1'b1;
      in_ch.command <= pending_cmds[0].cmd;
      in_ch.value <= pending_cmds[0].value;
      in_ch.position <= pending_cmds[0].position;
      void'(pending_cmds.pop_front());
      sent_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    int g;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      out_ch.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else if (out_fire) begin
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      out_ch.ready <= (g == 0);
      recv_gap <= (g > 0) ? g - 1 : 0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    cmd_item_t c;
    result_t e;
    if (!rst && in_ch.valid && in_ch.ready) begin
      c.cmd = olm_pkg::cmd_t'(in_ch.command);
      c.value = in_ch.value;
      c.position = in_ch.position;
      hist[c.cmd]++;
      apply_cmd(c);
      accepted++;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      checked++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result status=%0d data=%0d", out_ch.status,
                                   out_ch.data);
      end else begin
        e = expected_results.pop_front();
        if (out_ch.status !== e.status || out_ch.data !== e.data ||
            out_ch.found_position !== e.fpos || out_ch.last !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp st=%0d d=%0d fp=%0d l=%0d got st=%0d d=%0d fp=%0d l=%0d",
                     e.status, e.data, e.fpos, e.last, out_ch.status, out_ch.data,
                     out_ch.found_position, out_ch.last);
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_value(int pool);
    logic signed [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = 32'sh7fffffff;
      2: v = 32'sh80000000;
      default: v = $urandom_range(0, pool);
    endcase
    return v;
  endfunction

  task automatic queue_cmd(olm_pkg::cmd_t c, int v, int p);
    pending_cmds.push_back('{cmd: c, value: 32'(v), position: 16'(p)});
  endtask

  initial begin
    int k;
    olm_pkg::cmd_t c;
    in_ch.valid = 1'b0;
    in_ch.command = olm_pkg::CMD_LIST;
    in_ch.value = '0;
    in_ch.position = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // empty list cases, then positional inserts, searches and deletes on a short list
    queue_cmd(olm_pkg::CMD_LIST, 0, 0);
    queue_cmd(olm_pkg::CMD_DEL_HEAD, 0, 0);
    queue_cmd(olm_pkg::CMD_DEL_TAIL, 0, 0);
    queue_cmd(olm_pkg::CMD_DEL_VAL, 5, 0);
    queue_cmd(olm_pkg::CMD_SEARCH, 5, 0);
    queue_cmd(olm_pkg::CMD_INS_POS, 1, 0);
    queue_cmd(olm_pkg::CMD_INS_POS, 1, 2);
    queue_cmd(olm_pkg::CMD_INS_POS, 32'sh7fffffff, 1);
    queue_cmd(olm_pkg::CMD_INS_HEAD, 32'sh80000000, 0);
    queue_cmd(olm_pkg::CMD_INS_TAIL, -1, 16'hffff);
    queue_cmd(olm_pkg::CMD_INS_POS, 7, 4);
    queue_cmd(olm_pkg::CMD_INS_POS, 9, 2);
    queue_cmd(olm_pkg::CMD_INS_POS, 3, 16'hffff);
    queue_cmd(olm_pkg::CMD_LIST, 0, 0);
    queue_cmd(olm_pkg::CMD_SEARCH, -1, 0);
    queue_cmd(olm_pkg::CMD_SEARCH, 12345, 0);
    queue_cmd(olm_pkg::CMD_DEL_VAL, 12345, 0);
    queue_cmd(olm_pkg::CMD_DEL_VAL, 9, 0);
    queue_cmd(olm_pkg::CMD_DEL_HEAD, 0, 0);
    queue_cmd(olm_pkg::CMD_DEL_TAIL, 0, 0);
    queue_cmd(olm_pkg::CMD_LIST, 0, 0);
    // fill to capacity, then reject, search and list, then drain past empty
    for (k = 0; k < CAP; k++) queue_cmd(olm_pkg::CMD_INS_TAIL, k, 0);
    queue_cmd(olm_pkg::CMD_INS_HEAD, 1, 0);
    queue_cmd(olm_pkg::CMD_INS_POS, 1, 0);
    queue_cmd(olm_pkg::CMD_SEARCH, CAP - 3, 0);
    queue_cmd(olm_pkg::CMD_LIST, 0, 0);
    for (k = 0; k < CAP + 4; k++)
      queue_cmd(k[0] ? olm_pkg::CMD_DEL_TAIL : olm_pkg::CMD_DEL_HEAD, 0, 0);
    // random mix with a small value pool so searches hit
    for (k = 0; k < 112; k++) begin
      c = olm_pkg::cmd_t'($urandom_range(0, 7));
      if (c == olm_pkg::CMD_LIST && $urandom_range(0, 3) != 0) c = olm_pkg::CMD_INS_TAIL;
      queue_cmd(c, rand_value(15),
                ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535)) :
                                              int'($urandom_range(0, 20)));
    end
    queue_cmd(olm_pkg::CMD_LIST, 0, 0);
    wait (pending_cmds.size() == 0 && !in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (2 * CAP + 40) @(posedge clk);
    $display("%0d commands, %0d results checked; per command: %0d %0d %0d %0d %0d %0d %0d %0d",
             accepted, checked, hist[0], hist[1], hist[2], hist[3], hist[4], hist[5], hist[6],
             hist[7]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
